@@ rtl/mcd_pkg.sv @@
// mcd_pkg: shared widths, codes, types and defaults for the coefficient dequantizer
// no dependencies; used by the interfaces and every module in rtl except mcd_ram
package mcd_pkg;

  localparam int OPCODE_W = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 12;
  localparam int QS_W     = 5;
  localparam int COEF_W   = 16;
  localparam int WEIGHT_W = 8;
  localparam int SCALE_W  = 8;
  localparam int MAG_W    = 12;

  // first product: (2|c|+1) or |c| (13 bits) times qscale or dc scale (8 bits)
  localparam int P1_W = 21;
  localparam int P2_W = P1_W + WEIGHT_W;

  localparam int MCD_BLOCK_COEFFS = 64;
  localparam int MCD_QUEUE_DEPTH  = 2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_LOAD_INTRA = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_INTER = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DEQUANT    = 2'd2;

  localparam logic [1:0] REG_LUMA_DC_SCALE   = 2'd0;
  localparam logic [1:0] REG_CHROMA_DC_SCALE = 2'd1;
  localparam logic [1:0] REG_H263_MODE       = 2'd2;

  localparam logic [SCALE_W-1:0] DC_SCALE_RESET = 8'd8;

  typedef enum logic [1:0] {
    KIND_DC,
    KIND_ZERO,
    KIND_INTRA,
    KIND_INTER
  } kind_t;

  typedef struct packed {
    logic [SCALE_W-1:0] luma_dc_scale;
    logic [SCALE_W-1:0] chroma_dc_scale;
    logic               h263_mode;
  } mcd_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t               kind;
    logic                neg;
    logic [MAG_W-1:0]    mag;
    logic [QS_W-1:0]     qs;
    logic [WEIGHT_W-1:0] w;     // weight, or dc scale for intra dc
    logic [POS_W-1:0]    pos;
  } mcd_item_t;

endpackage

@@ rtl/mcd_if.sv @@
// mcd_if: valid/ready channel interfaces for requests and results
// depends on mcd_pkg for field widths
interface mcd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mcd_pkg::OPCODE_W-1:0]         opcode;
  logic [mcd_pkg::POS_W-1:0]            position;
  logic signed [mcd_pkg::VALUE_W-1:0]   value_in;
  logic [mcd_pkg::QS_W-1:0]             quant_scale;
  logic                                 intra_block;
  logic                                 is_chroma;

  modport source (output valid, opcode, position, value_in, quant_scale, intra_block,
                  is_chroma, input ready);
  modport sink (input valid, opcode, position, value_in, quant_scale, intra_block,
                is_chroma, output ready);
endinterface

interface mcd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcd_pkg::COEF_W-1:0]   coefficient_out;
  logic [mcd_pkg::POS_W-1:0]           position_out;

  modport source (output valid, coefficient_out, position_out, input ready);
  modport sink (input valid, coefficient_out, position_out, output ready);
endinterface

@@ rtl/mcd_ram.sv @@
// mcd_ram: generic single-write, single-read RAM with registered read data
// no package dependencies
module mcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mcd_front.sv @@
// mcd_front: accepts requests, writes weight loads, classifies coefficients
// and reads their weight; depends on mcd_pkg, mcd_if and mcd_ram
module mcd_front #(
  parameter int BLOCK_COEFFS = mcd_pkg::MCD_BLOCK_COEFFS
) (
  input  logic               clk,
  input  logic               rst_n,
  mcd_in_if.sink             in_ch,
  input  mcd_pkg::mcd_cfg_t  cfg,
  input  logic               q_full,
  output logic               q_push,
  output mcd_pkg::mcd_item_t q_item
);
  import mcd_pkg::*;

  localparam int AW = $clog2(BLOCK_COEFFS);
  localparam int RW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam logic [RW-1:0] NB = RW'(BLOCK_COEFFS);
  // position < 64 and BLOCK_COEFFS >= 16, so three subtractions settle the remainder
  localparam int FOLDS = 3;

  logic           in_fire;
  logic           is_deq;
  logic           we_intra;
  logic           we_inter;
  logic [RW-1:0]  rem;
  logic [AW-1:0]  idx;
  logic           neg;
  logic [MAG_W-1:0] mag;
  kind_t          kind;
  logic [WEIGHT_W-1:0] intra_rd;
  logic [WEIGHT_W-1:0] inter_rd;

  logic             s1_v_r, s1_v_nxt;
  kind_t            s1_kind_r;
  logic             s1_neg_r;
  logic [MAG_W-1:0] s1_mag_r;
  logic [QS_W-1:0]  s1_qs_r;
  logic [SCALE_W-1:0] s1_scale_r;
  logic [POS_W-1:0] s1_pos_r;

  assign in_ch.ready = !s1_v_r || !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    is_deq   = 1'b0;
    we_intra = 1'b0;
    we_inter = 1'b0;
    unique case (in_ch.opcode)
      OP_LOAD_INTRA: we_intra = in_fire;
      OP_LOAD_INTER: we_inter = in_fire;
      OP_DEQUANT:    is_deq   = in_fire;
      default: ;
    endcase
  end

  always_comb begin
    rem = RW'(in_ch.position);
    for (int k = 0; k < FOLDS; k++) begin
      if (rem >= NB) begin
        rem = rem - NB;
      end
    end
  end
  assign idx = rem[AW-1:0];

  assign neg = in_ch.value_in[VALUE_W-1];
  assign mag = neg ? MAG_W'(-in_ch.value_in) : MAG_W'(in_ch.value_in);

  always_comb begin
    if (in_ch.intra_block && in_ch.position == '0) begin
      kind = KIND_DC;
    end else if (mag == '0) begin
      kind = KIND_ZERO;
    end else if (in_ch.intra_block && !cfg.h263_mode) begin
      kind = KIND_INTRA;
    end else begin
      kind = KIND_INTER;
    end
  end

  mcd_ram #(.WIDTH(WEIGHT_W), .DEPTH(BLOCK_COEFFS)) u_intra_ram (
    .clk   (clk),
    .we    (we_intra),
    .waddr (idx),
    .wdata (in_ch.value_in[WEIGHT_W-1:0]),
    .re    (is_deq),
    .raddr (idx),
    .rdata (intra_rd)
  );

  mcd_ram #(.WIDTH(WEIGHT_W), .DEPTH(BLOCK_COEFFS)) u_inter_ram (
    .clk   (clk),
    .we    (we_inter),
    .waddr (idx),
    .wdata (in_ch.value_in[WEIGHT_W-1:0]),
    .re    (is_deq),
    .raddr (idx),
    .rdata (inter_rd)
  );

  assign q_push = s1_v_r && !q_full;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (is_deq) begin
      s1_v_nxt = 1'b1;
    end else if (q_push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_deq) begin
      s1_kind_r  <= kind;
      s1_neg_r   <= neg;
      s1_mag_r   <= mag;
      s1_qs_r    <= in_ch.quant_scale;
      s1_scale_r <= in_ch.is_chroma ? cfg.chroma_dc_scale : cfg.luma_dc_scale;
      s1_pos_r   <= in_ch.position;
    end
  end

  always_comb begin
    q_item.kind = s1_kind_r;
    q_item.neg  = s1_neg_r;
    q_item.mag  = s1_mag_r;
    q_item.qs   = s1_qs_r;
    q_item.pos  = s1_pos_r;
    case (s1_kind_r)
      KIND_DC:    q_item.w = s1_scale_r;
      KIND_INTRA: q_item.w = intra_rd;
      default:    q_item.w = inter_rd;
    endcase
  end

endmodule

@@ rtl/mcd_queue.sv @@
// mcd_queue: short register fifo between front and back
// depends on mcd_pkg for the item type
module mcd_queue #(
  parameter int DEPTH = mcd_pkg::MCD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mcd_pkg::mcd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output mcd_pkg::mcd_item_t pop_item
);
  import mcd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  mcd_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = count_r == FULL_COUNT;
  assign pop_valid = count_r != '0;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/mcd_back.sv @@
// mcd_back: two multiply stages, odd forcing, sign restore and result register
// depends on mcd_pkg and mcd_if
module mcd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mcd_pkg::mcd_item_t q_item,
  output logic               q_pop,
  mcd_out_if.source          out_ch
);
  import mcd_pkg::*;

  localparam int MA_W = MAG_W + 1;

  logic               b_ready;
  logic               a_ready;
  logic [MA_W-1:0]    ma;
  logic [SCALE_W-1:0] mb;

  logic               a_v_r, a_v_nxt;
  kind_t              a_kind_r;
  logic               a_neg_r;
  logic [P1_W-1:0]    a_p1_r;
  logic [WEIGHT_W-1:0] a_w_r;
  logic [POS_W-1:0]   a_pos_r;

  logic [P2_W-1:0]    p2;
  logic [COEF_W-1:0]  v16;
  logic [COEF_W-1:0]  mag16;
  logic [COEF_W-1:0]  res16;

  logic               out_v_r, out_v_nxt;
  logic [COEF_W-1:0]  coef_r;
  logic [POS_W-1:0]   opos_r;

  assign b_ready = !out_v_r || out_ch.ready;
  assign a_ready = !a_v_r || b_ready;
  assign q_pop   = q_valid && a_ready;

  // first product: |c|*dcscale, |c|*qs or (2|c|+1)*qs
  always_comb begin
    case (q_item.kind) inside
      KIND_DC, KIND_INTRA: ma = {1'b0, q_item.mag};
      default:             ma = {q_item.mag, 1'b1};
    endcase
    if (q_item.kind == KIND_DC) begin
      mb = q_item.w;
    end else begin
      mb = SCALE_W'(q_item.qs);
    end
  end

  always_comb begin
    a_v_nxt = a_v_r;
    if (q_pop) begin
      a_v_nxt = 1'b1;
    end else if (b_ready) begin
      a_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_kind_r <= q_item.kind;
      a_neg_r  <= q_item.neg;
      a_p1_r   <= P1_W'(ma) * P1_W'(mb);
      a_w_r    <= q_item.w;
      a_pos_r  <= q_item.pos;
    end
  end

  // second product with the weight, then shift and force odd (only low 16 bits matter)
  always_comb begin
    p2 = P2_W'(a_p1_r) * P2_W'(a_w_r);
    if (a_kind_r == KIND_INTRA) begin
      v16 = p2[COEF_W+2:3];
    end else begin
      v16 = p2[COEF_W+3:4];
    end
    case (a_kind_r)
      KIND_DC:   mag16 = a_p1_r[COEF_W-1:0];
      KIND_ZERO: mag16 = '0;
      default:   mag16 = (v16 - 1'b1) | COEF_W'(1);
    endcase
    res16 = a_neg_r ? COEF_W'(-mag16) : mag16;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (a_v_r && b_ready) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r && b_ready) begin
      coef_r <= res16;
      opos_r <= a_pos_r;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.coefficient_out = coef_r;
  assign out_ch.position_out    = opos_r;

endmodule

@@ rtl/mpeg1_coefficient_dequantizer.sv @@
// mpeg1_coefficient_dequantizer: top level with config registers, front, queue and back
// depends on mcd_pkg, mcd_if, mcd_ram, mcd_front, mcd_queue, mcd_back
//
//   channel  direction  handshake        payload
//   in_ch    in         valid/ready      opcode, position, value_in, quant_scale,
//                                        intra_block, is_chroma
//   out_ch   out        valid/ready      coefficient_out, position_out
//   apb      in         psel/penable     paddr, pwdata, prdata (luma/chroma dc scale, h263)
//
// one request per cycle is taken while in_ch.ready is high; weight loads and opcode three give no result
// a coefficient request goes into the weight ram read and front register at the edge that accepts it,
// then passes the queue, the first multiply, and the second multiply
// into the result register
// synchronous active-low reset clears control state and sets the config defaults
// weight memories hold nothing at reset; each entry must be loaded before use
// a stalled output fills the back stage, then the queue and the front register,
// then drops in_ch.ready
module mpeg1_coefficient_dequantizer #(
  parameter int BLOCK_COEFFS = mcd_pkg::MCD_BLOCK_COEFFS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mcd_in_if.sink                            in_ch,
  mcd_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mcd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mcd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import mcd_pkg::*;

  mcd_cfg_t  cfg_r, cfg_nxt;
  logic      cfg_wr;
  logic [1:0] reg_idx;

  logic      q_push;
  logic      q_full;
  mcd_item_t q_push_item;
  logic      q_pop;
  logic      q_valid;
  mcd_item_t q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_LUMA_DC_SCALE:   cfg_nxt.luma_dc_scale   = pwdata[SCALE_W-1:0];
        REG_CHROMA_DC_SCALE: cfg_nxt.chroma_dc_scale = pwdata[SCALE_W-1:0];
        REG_H263_MODE:       cfg_nxt.h263_mode       = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.luma_dc_scale   <= DC_SCALE_RESET;
      cfg_r.chroma_dc_scale <= DC_SCALE_RESET;
      cfg_r.h263_mode       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LUMA_DC_SCALE:   prdata = CFG_DATA_W'(cfg_r.luma_dc_scale);
      REG_CHROMA_DC_SCALE: prdata = CFG_DATA_W'(cfg_r.chroma_dc_scale);
      REG_H263_MODE:       prdata = CFG_DATA_W'(cfg_r.h263_mode);
      default:             prdata = '0;
    endcase
  end

  mcd_front #(.BLOCK_COEFFS(BLOCK_COEFFS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_push_item)
  );

  mcd_queue #(.DEPTH(MCD_QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_head)
  );

  mcd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue push while full");

  a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_luma_scale_written: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && reg_idx == REG_LUMA_DC_SCALE) |=>
      cfg_r.luma_dc_scale == $past(pwdata[SCALE_W-1:0]))
    else $error("luma dc scale write lost");

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for mpeg1_coefficient_dequantizer
// runs a directed table, then random phases across register settings, against a scoreboard
// depends on mcd_pkg, mcd_if and the dequantizer rtl
`timescale 1ns / 1ps

module testbench;
  import mcd_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int DRAIN_CYCLES    = 8;
  localparam int STALL_LIMIT     = 1000;

  typedef struct {
    logic [OPCODE_W-1:0]       op;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    logic [QS_W-1:0]           qs;
    logic                      intra;
    logic                      chroma;
  } coef_req_t;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [POS_W-1:0]         pos;
  } coef_result_t;

  typedef struct {
    coef_req_t                req;
    bit                       fixed;
    logic signed [COEF_W-1:0] coef;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mcd_in_if  in_ch ();
  mcd_out_if out_ch ();

  mpeg1_coefficient_dequantizer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the weight memories and registers
  logic [WEIGHT_W-1:0] intra_w [MCD_BLOCK_COEFFS];
  logic [WEIGHT_W-1:0] inter_w [MCD_BLOCK_COEFFS];
  bit                  intra_ok [MCD_BLOCK_COEFFS];
  bit                  inter_ok [MCD_BLOCK_COEFFS];
  logic [SCALE_W-1:0]  luma_scale;
  logic [SCALE_W-1:0]  chroma_scale;
  logic                h263_on;

  coef_result_t pending_coefs [$];
  dir_row_t     directed_rows [$];

  bit sender_fast;
  bit rcv_fast;
  int n_requests;
  int n_loads;
  int n_results;
  int n_errors;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  function automatic coef_req_t make_req(input logic [OPCODE_W-1:0] op, input int pos,
                                         input int val, input int qs, input bit intra,
                                         input bit chroma);
    coef_req_t r;
    r.op     = op;
    r.pos    = pos[POS_W-1:0];
    r.val    = val[VALUE_W-1:0];
    r.qs     = qs[QS_W-1:0];
    r.intra  = intra;
    r.chroma = chroma;
    return r;
  endfunction

  function automatic void add_row(input logic [OPCODE_W-1:0] op, input int pos, input int val,
                                  input int qs, input bit intra, input bit chroma,
                                  input bit fixed, input int coef);
    dir_row_t row;
    row.req   = make_req(op, pos, val, qs, intra, chroma);
    row.fixed = fixed;
    row.coef  = coef[COEF_W-1:0];
    directed_rows.push_back(row);
  endfunction

  // expected coefficient for a dequantize request, from the shadow state
  function automatic logic signed [COEF_W-1:0] dequant_coef(input coef_req_t r);
    logic [31:0] mag;
    logic [31:0] v;
    logic [31:0] prod;
    logic [SCALE_W-1:0] sc;
    if (r.intra && r.pos == 0) begin
      sc = r.chroma ? chroma_scale : luma_scale;
      prod = {{20{r.val[VALUE_W-1]}}, r.val} * {24'd0, sc};
      return prod[COEF_W-1:0];
    end
    mag = r.val[VALUE_W-1] ? (32'h1000 - {20'd0, r.val}) : {20'd0, r.val};
    if (mag == 0)
      return '0;
    if (r.intra && !h263_on)
      v = (mag * {27'd0, r.qs} * {24'd0, intra_w[r.pos]}) >> 3;
    else
      v = ((32'd2 * mag + 32'd1) * {27'd0, r.qs} * {24'd0, inter_w[r.pos]}) >> 4;
    v = (v - 32'd1) | 32'd1;
    if (r.val[VALUE_W-1])
      v = 32'd0 - v;
    return v[COEF_W-1:0];
  endfunction

  // true when a dequantize request would read a weight entry never loaded
  function automatic bit weight_missing(input coef_req_t r);
    if (r.op != OP_DEQUANT || (r.intra && r.pos == 0) || r.val == 0)
      return 1'b0;
    if (r.intra && !h263_on)
      return !intra_ok[r.pos];
    return !inter_ok[r.pos];
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_coef();
    int tmp;
    case ($urandom_range(0, 7)) inside
      0: return '0;
      1, 2: begin
        tmp = int'($urandom_range(0, 16)) - 8;
        return tmp[VALUE_W-1:0];
      end
      3: return $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_weight();
    case ($urandom_range(0, 15))
      0: return 12'sh000;
      1: return 12'sh001;
      2: return 12'sh0FF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic coef_req_t gen_request();
    coef_req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r = make_req(OP_DEQUANT, $urandom_range(0, 63), pick_coef(), $urandom_range(1, 31),
                 1'($urandom), 1'($urandom));
    if (sel < 4) begin
      r.op = OP_RESERVED;
      r.qs = QS_W'($urandom);
    end else if (sel < 22) begin
      r.op  = $urandom_range(0, 1) ? OP_LOAD_INTRA : OP_LOAD_INTER;
      r.val = pick_weight();
    end else begin
      if ($urandom_range(0, 3) == 0)
        r.pos = '0;
      if ($urandom_range(0, 19) == 0)
        r.qs = '0;
    end
    // load the entry first instead of reading it unwritten
    if (weight_missing(r)) begin
      r.op  = (r.intra && !h263_on) ? OP_LOAD_INTRA : OP_LOAD_INTER;
      r.val = pick_weight();
    end
    return r;
  endfunction

  task automatic send_item(input coef_req_t r, input bit fixed,
                           input logic signed [COEF_W-1:0] fixed_coef);
    int gap;
    coef_result_t res;
    gap = sender_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= r.op;
    in_ch.position    <= r.pos;
    in_ch.value_in    <= r.val;
    in_ch.quant_scale <= r.qs;
    in_ch.intra_block <= r.intra;
    in_ch.is_chroma   <= r.chroma;
    do @(posedge clk); while (!in_ch.ready);
    n_requests++;
    case (r.op)
      OP_LOAD_INTRA: begin
        intra_w[r.pos]  = r.val[WEIGHT_W-1:0];
        intra_ok[r.pos] = 1'b1;
        n_loads++;
      end
      OP_LOAD_INTER: begin
        inter_w[r.pos]  = r.val[WEIGHT_W-1:0];
        inter_ok[r.pos] = 1'b1;
        n_loads++;
      end
      OP_DEQUANT: begin
        res.coef = fixed ? fixed_coef : dequant_coef(r);
        res.pos  = r.pos;
        pending_coefs.push_back(res);
      end
      default: ;
    endcase
  endtask

  // wait for every coefficient, then let any load still in flight retire
  task automatic settle();
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic write, input logic [1:0] code,
                           input logic [CFG_DATA_W-1:0] wdata,
                           output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= CFG_ADDR_W'({code, 2'b00});
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic set_config(input logic [SCALE_W-1:0] luma, input logic [SCALE_W-1:0] chroma,
                            input logic h263);
    logic [1:0]            codes [3];
    logic [CFG_DATA_W-1:0] vals [3];
    logic [CFG_DATA_W-1:0] masks [3];
    logic [CFG_DATA_W-1:0] rd;
    codes = '{REG_LUMA_DC_SCALE, REG_CHROMA_DC_SCALE, REG_H263_MODE};
    vals  = '{CFG_DATA_W'(luma), CFG_DATA_W'(chroma), CFG_DATA_W'(h263)};
    masks = '{32'hFF, 32'hFF, 32'h1};
    // junk in the unused upper bits must be ignored
    for (int i = 0; i < 3; i++)
      apb_cycle(1'b1, codes[i], ($urandom & ~masks[i]) | vals[i], rd);
    for (int i = 0; i < 3; i++) begin
      apb_cycle(1'b0, codes[i], '0, rd);
      if ((rd & masks[i]) != vals[i])
        report_mismatch($sformatf("register %0d reads %0h, written %0h", codes[i],
                                  rd & masks[i], vals[i]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    luma_scale   = luma;
    chroma_scale = chroma;
    h263_on      = h263;
  endtask

  // result side: random stalls, compare against the oldest expectation
  initial begin : result_sink
    int stall;
    coef_result_t want;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        n_results++;
        if (pending_coefs.size() == 0) begin
          report_mismatch($sformatf("unexpected result at position %0d",
                                    out_ch.position_out));
        end else begin
          want = pending_coefs.pop_front();
          if (out_ch.coefficient_out !== want.coef)
            report_mismatch($sformatf("position %0d: coefficient %0d, expected %0d",
                                      want.pos, out_ch.coefficient_out, want.coef));
          if (out_ch.position_out !== want.pos)
            report_mismatch($sformatf("position_out %0d, expected %0d",
                                      out_ch.position_out, want.pos));
        end
        stall = rcv_fast ? 0 : $urandom_range(0, 8);
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall--;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d coefficients outstanding", quiet,
                 pending_coefs.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    coef_req_t r;
    int count;
    logic [SCALE_W-1:0] luma;
    logic [SCALE_W-1:0] chroma;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_LOAD_INTRA;
    in_ch.position    = '0;
    in_ch.value_in    = '0;
    in_ch.quant_scale = '0;
    in_ch.intra_block = 1'b0;
    in_ch.is_chroma   = 1'b0;
    luma_scale        = DC_SCALE_RESET;
    chroma_scale      = DC_SCALE_RESET;
    h263_on           = 1'b0;

    //      op             pos  value  qs  intra chroma fixed coef
    add_row(OP_DEQUANT,      0,     5,  1, 1, 0, 1,     40);
    add_row(OP_DEQUANT,      0, -2048, 31, 1, 0, 1, -16384);
    add_row(OP_DEQUANT,      0,  2047,  0, 1, 1, 1,  16376);
    add_row(OP_DEQUANT,     17,     0, 31, 0, 0, 1,      0);
    add_row(OP_DEQUANT,     63,     0, 31, 1, 1, 1,      0);
    add_row(OP_LOAD_INTRA,  63, 'h7FF,  0, 0, 0, 0,      0);
    add_row(OP_LOAD_INTER,  63,    -1, 31, 1, 1, 0,      0);
    add_row(OP_LOAD_INTRA,   1, 'h100,  0, 0, 0, 0,      0);
    add_row(OP_LOAD_INTER,   1,    16,  0, 0, 0, 0,      0);
    add_row(OP_LOAD_INTER,   0,    16,  0, 0, 0, 0,      0);
    add_row(OP_RESERVED,     5,   100,  3, 1, 0, 0,      0);
    add_row(OP_DEQUANT,     63,  2047, 31, 1, 0, 0,      0);
    add_row(OP_DEQUANT,     63, -2048, 31, 1, 0, 0,      0);
    add_row(OP_DEQUANT,     63,  2047, 31, 0, 0, 0,      0);
    add_row(OP_DEQUANT,     63, -2048, 31, 0, 1, 0,      0);
    add_row(OP_DEQUANT,      1,     3,  7, 1, 0, 1,     -1);
    add_row(OP_DEQUANT,      1,    -3,  7, 1, 0, 1,      1);
    add_row(OP_DEQUANT,      1,     5,  0, 0, 0, 1,     -1);
    add_row(OP_DEQUANT,      0,     1,  1, 0, 0, 1,      3);
    add_row(OP_DEQUANT,      0,    -1,  1, 0, 0, 1,     -3);
    add_row(OP_DEQUANT,      1,     1,  1, 0, 1, 1,      3);
    add_row(OP_DEQUANT,      1, -2048, 31, 0, 0, 0,      0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].coef);
    in_ch.valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: set_config(8'd1, 8'd255, 1'b0);
        1: set_config(8'd255, 8'd1, 1'b1);
        2: set_config(8'd0, 8'd8, 1'b0);
        default: begin
          luma   = SCALE_W'($urandom_range(1, 255));
          chroma = SCALE_W'($urandom_range(1, 255));
          set_config(luma, chroma, 1'(p));
        end
      endcase
      sender_fast = (p % 3 == 2);
      rcv_fast    = (p % 4 == 2);
      count = 0;
      if (p == 0) begin
        // fill both weight tables so the stream reaches every formula early
        for (int k = 0; k < MCD_BLOCK_COEFFS; k++) begin
          send_item(make_req(OP_LOAD_INTRA, k, pick_weight(), 0, 1'b0, 1'b0), 1'b0, '0);
          send_item(make_req(OP_LOAD_INTER, k, pick_weight(), 0, 1'b0, 1'b0), 1'b0, '0);
        end
        count = 2 * MCD_BLOCK_COEFFS;
      end
      while (count < ITEMS_PER_PHASE) begin
        r = gen_request();
        send_item(r, 1'b0, '0);
        if (r.op != OP_RESERVED)
          count++;
      end
      in_ch.valid <= 1'b0;
    end
    settle();

    $display("covered %0d requests (%0d weight loads) and %0d coefficients", n_requests,
             n_loads, n_results);
    $display("across %0d register settings after the reset defaults", NUM_PHASES);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
